[sv/oct_enc_pkg.sv]
// shared constants and types for the octahedral normal encoder
// no dependencies; imported by oct_enc_div_stage, octahedral_normal_encoder_top and its testbench
`default_nettype none

package oct_enc_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int OUT_BITS           = 16;
    // quotient bits: results lie in 0..32767
    localparam int Q_BITS             = 15;
    // scale 32767 doubled is 2^(Q_BITS+1) - 2
    localparam int SCALE2_SHIFT       = Q_BITS + 1;

    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic zero;
    } t_side;

endpackage

`default_nettype wire

[sv/octahedral_normal_encoder_top.sv]
// octahedral normal encoder: registered stages from input transaction to result
// (absolute values, sum and fold, numerator build, 15 one-bit division steps, sign)
// throughput one transaction per cycle while no stall holds the pipeline, set by the fully pipelined divider
// a stall holds each stage only where the stage after it is full
// reset clears the stage valid bits only; payload registers are not reset
// depends on oct_enc_pkg and oct_enc_div_stage
`default_nettype none

module octahedral_normal_encoder_top #(
    parameter int COMPONENT_BITS = oct_enc_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_normal_x,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_normal_y,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_normal_z,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [oct_enc_pkg::OUT_BITS-1:0] o_oct_u,
    output logic signed [oct_enc_pkg::OUT_BITS-1:0] o_oct_v
);
    import oct_enc_pkg::*;

    localparam int CB  = COMPONENT_BITS;
    localparam int MW  = CB + 1;
    localparam int DW  = CB + 2;
    localparam int NW  = MW + SCALE2_SHIFT;
    localparam int NST = Q_BITS + 4;
    localparam int DIV0 = 3;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_en;

    // stage a: magnitudes
    logic [CB-1:0] r_ax;
    logic [CB-1:0] r_ay;
    logic [CB-1:0] r_az;
    logic          r_sx;
    logic          r_sy;
    logic          r_zn;

    // stage b: sum and folded numerators
    logic [MW-1:0] r_s;
    logic [MW-1:0] r_mu;
    logic [MW-1:0] r_mv;
    t_side         r_b_side;

    // stage c feeds the division chain
    logic [NW-1:0] w_num_u;
    logic [NW-1:0] w_num_v;

    logic [DW-1:0]     w_den   [0:Q_BITS];
    logic [DW-1:0]     w_rem_u [0:Q_BITS];
    logic [Q_BITS-1:0] w_low_u [0:Q_BITS];
    logic [Q_BITS-1:0] w_quo_u [0:Q_BITS];
    logic [DW-1:0]     w_rem_v [0:Q_BITS];
    logic [Q_BITS-1:0] w_low_v [0:Q_BITS];
    logic [Q_BITS-1:0] w_quo_v [0:Q_BITS];
    t_side             w_side  [0:Q_BITS];

    logic [DW-1:0]     r_c_den;
    logic [DW-1:0]     r_c_rem_u;
    logic [Q_BITS-1:0] r_c_low_u;
    logic [DW-1:0]     r_c_rem_v;
    logic [Q_BITS-1:0] r_c_low_v;
    t_side             r_c_side;

    logic [OUT_BITS-1:0] r_oct_u;
    logic [OUT_BITS-1:0] r_oct_v;

    logic [CB-1:0] w_ax;
    logic [CB-1:0] w_ay;
    logic [CB-1:0] w_az;

    // a stage may load when empty or when its contents move on
    always_comb begin
        w_en[NST] = i_out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready = w_en[0];

    always_comb begin
        w_ax = i_normal_x[CB-1] ? CB'(~i_normal_x + 1'b1) : CB'(i_normal_x);
        w_ay = i_normal_y[CB-1] ? CB'(~i_normal_y + 1'b1) : CB'(i_normal_y);
        w_az = i_normal_z[CB-1] ? CB'(~i_normal_z + 1'b1) : CB'(i_normal_z);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_ax <= w_ax;
            r_ay <= w_ay;
            r_az <= w_az;
            r_sx <= i_normal_x[CB-1];
            r_sy <= i_normal_y[CB-1];
            r_zn <= i_normal_z[CB-1];
        end
    end

    // lower hemisphere: s - |y| = |x| + |z|, s - |x| = |y| + |z|
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s            <= MW'(r_ax) + MW'(r_ay) + MW'(r_az);
            r_mu           <= r_zn ? MW'(r_ax) + MW'(r_az) : MW'(r_ax);
            r_mv           <= r_zn ? MW'(r_ay) + MW'(r_az) : MW'(r_ay);
            r_b_side.neg_u <= r_sx;
            r_b_side.neg_v <= r_sy;
            r_b_side.zero  <= ((r_ax | r_ay | r_az) == '0);
        end
    end

    // numerator 2*32767*m + s, divisor 2*s
    always_comb begin
        w_num_u = NW'({r_mu, {SCALE2_SHIFT{1'b0}}}) - NW'({r_mu, 1'b0}) + NW'(r_s);
        w_num_v = NW'({r_mv, {SCALE2_SHIFT{1'b0}}}) - NW'({r_mv, 1'b0}) + NW'(r_s);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_c_den   <= {r_s, 1'b0};
            r_c_rem_u <= w_num_u[NW-1:Q_BITS];
            r_c_low_u <= w_num_u[Q_BITS-1:0];
            r_c_rem_v <= w_num_v[NW-1:Q_BITS];
            r_c_low_v <= w_num_v[Q_BITS-1:0];
            r_c_side  <= r_b_side;
        end
    end

    assign w_den[0]   = r_c_den;
    assign w_rem_u[0] = r_c_rem_u;
    assign w_low_u[0] = r_c_low_u;
    assign w_quo_u[0] = '0;
    assign w_rem_v[0] = r_c_rem_v;
    assign w_low_v[0] = r_c_low_v;
    assign w_quo_v[0] = '0;
    assign w_side[0]  = r_c_side;

    for (genvar g = 0; g < Q_BITS; g++) begin : g_div
        oct_enc_div_stage #(
            .DW (DW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_load  (w_en[DIV0+g]),
            .i_den   (w_den[g]),
            .i_rem_u (w_rem_u[g]),
            .i_low_u (w_low_u[g]),
            .i_quo_u (w_quo_u[g]),
            .i_rem_v (w_rem_v[g]),
            .i_low_v (w_low_v[g]),
            .i_quo_v (w_quo_v[g]),
            .i_side  (w_side[g]),
            .o_den   (w_den[g+1]),
            .o_rem_u (w_rem_u[g+1]),
            .o_low_u (w_low_u[g+1]),
            .o_quo_u (w_quo_u[g+1]),
            .o_rem_v (w_rem_v[g+1]),
            .o_low_v (w_low_v[g+1]),
            .o_quo_v (w_quo_v[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // quotient is at most 32767 so it fits the output without a clamp
    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            if (w_side[Q_BITS].zero) begin
                r_oct_u <= '0;
                r_oct_v <= '0;
            end else begin
                r_oct_u <= w_side[Q_BITS].neg_u ? OUT_BITS'(0) - {1'b0, w_quo_u[Q_BITS]}
                                                : {1'b0, w_quo_u[Q_BITS]};
                r_oct_v <= w_side[Q_BITS].neg_v ? OUT_BITS'(0) - {1'b0, w_quo_v[Q_BITS]}
                                                : {1'b0, w_quo_v[Q_BITS]};
            end
        end
    end

    assign o_out_valid = r_vld[NST-1];
    assign o_oct_u     = r_oct_u;
    assign o_oct_v     = r_oct_v;

    // w_den past the last step is unused downstream
    logic w_unused;
    assign w_unused = ^{w_den[Q_BITS], w_rem_u[Q_BITS], w_low_u[Q_BITS],
                        w_rem_v[Q_BITS], w_low_v[Q_BITS]};

endmodule

`default_nettype wire

[sv/oct_enc_div_stage.sv]
// one registered restoring-division step for both coordinates sharing a divisor
// depends on oct_enc_pkg
`default_nettype none

module oct_enc_div_stage #(
    parameter int DW = 18
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire logic [DW-1:0]                 i_den,
    input  wire logic [DW-1:0]                 i_rem_u,
    input  wire logic [oct_enc_pkg::Q_BITS-1:0] i_low_u,
    input  wire logic [oct_enc_pkg::Q_BITS-1:0] i_quo_u,
    input  wire logic [DW-1:0]                 i_rem_v,
    input  wire logic [oct_enc_pkg::Q_BITS-1:0] i_low_v,
    input  wire logic [oct_enc_pkg::Q_BITS-1:0] i_quo_v,
    input  wire oct_enc_pkg::t_side            i_side,
    output logic      [DW-1:0]                 o_den,
    output logic      [DW-1:0]                 o_rem_u,
    output logic      [oct_enc_pkg::Q_BITS-1:0] o_low_u,
    output logic      [oct_enc_pkg::Q_BITS-1:0] o_quo_u,
    output logic      [DW-1:0]                 o_rem_v,
    output logic      [oct_enc_pkg::Q_BITS-1:0] o_low_v,
    output logic      [oct_enc_pkg::Q_BITS-1:0] o_quo_v,
    output oct_enc_pkg::t_side                 o_side
);
    import oct_enc_pkg::*;

    logic [DW:0]     w_try_u;
    logic [DW:0]     w_try_v;
    logic            w_ge_u;
    logic            w_ge_v;
    logic [DW-1:0]   n_rem_u;
    logic [DW-1:0]   n_rem_v;

    logic [DW-1:0]     r_den;
    logic [DW-1:0]     r_rem_u;
    logic [Q_BITS-1:0] r_low_u;
    logic [Q_BITS-1:0] r_quo_u;
    logic [DW-1:0]     r_rem_v;
    logic [Q_BITS-1:0] r_low_v;
    logic [Q_BITS-1:0] r_quo_v;
    t_side             r_side;

    always_comb begin
        w_try_u = {i_rem_u, i_low_u[Q_BITS-1]};
        w_try_v = {i_rem_v, i_low_v[Q_BITS-1]};
        w_ge_u  = (w_try_u >= {1'b0, i_den});
        w_ge_v  = (w_try_v >= {1'b0, i_den});
        n_rem_u = w_ge_u ? DW'(w_try_u - {1'b0, i_den}) : DW'(w_try_u);
        n_rem_v = w_ge_v ? DW'(w_try_v - {1'b0, i_den}) : DW'(w_try_v);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_den   <= i_den;
            r_rem_u <= n_rem_u;
            r_low_u <= {i_low_u[Q_BITS-2:0], 1'b0};
            r_quo_u <= {i_quo_u[Q_BITS-2:0], w_ge_u};
            r_rem_v <= n_rem_v;
            r_low_v <= {i_low_v[Q_BITS-2:0], 1'b0};
            r_quo_v <= {i_quo_v[Q_BITS-2:0], w_ge_v};
            r_side  <= i_side;
        end
    end

    assign o_den   = r_den;
    assign o_rem_u = r_rem_u;
    assign o_low_u = r_low_u;
    assign o_quo_u = r_quo_u;
    assign o_rem_v = r_rem_v;
    assign o_low_v = r_low_v;
    assign o_quo_v = r_quo_v;
    assign o_side  = r_side;

endmodule

`default_nettype wire

[sim/octahedral_normal_encoder_top_tb.sv]
`timescale 1ns / 1ps
// testbench for octahedral_normal_encoder_top: directed and random normals, bursty sender,
// patterned receiver stalls, codes checked in order against an exact integer encoder
// depends on oct_enc_pkg and octahedral_normal_encoder_top

module octahedral_normal_encoder_top_tb;

    import oct_enc_pkg::*;

    localparam int CB            = COMPONENT_BITS_DEF;
    localparam longint OCT_SCALE = 32767;
    localparam int RANDOM_ITEMS  = 900;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;

    typedef logic signed [CB-1:0]       t_comp;
    typedef logic signed [OUT_BITS-1:0] t_coord;

    typedef struct {
        t_coord u;
        t_coord v;
    } t_oct_code;

    class oct_code_tracker;
        t_oct_code pending_codes[$];
        int        mismatches = 0;

        function t_coord round_scaled(longint mag, longint sum, bit neg);
            longint q;
            q = (2 * OCT_SCALE * mag + sum) / (2 * sum);
            if (q > OCT_SCALE) q = OCT_SCALE;
            return neg ? t_coord'(-q) : t_coord'(q);
        endfunction

        function t_oct_code encode_octahedral(t_comp x, t_comp y, t_comp z);
            longint    ax, ay, az, sum;
            t_oct_code code;
            ax  = (x < 0) ? -longint'(x) : longint'(x);
            ay  = (y < 0) ? -longint'(y) : longint'(y);
            az  = (z < 0) ? -longint'(z) : longint'(z);
            sum = ax + ay + az;
            if (sum == 0) begin
                code.u = '0;
                code.v = '0;
            end else if (z < 0) begin
                // lower hemisphere folded, zero counts as positive
                code.u = round_scaled(sum - ay, sum, x < 0);
                code.v = round_scaled(sum - ax, sum, y < 0);
            end else begin
                code.u = round_scaled(ax, sum, x < 0);
                code.v = round_scaled(ay, sum, y < 0);
            end
            return code;
        endfunction

        function void note_normal(t_comp x, t_comp y, t_comp z);
            pending_codes.push_back(encode_octahedral(x, y, z));
        endfunction

        function void check_code(t_coord got_u, t_coord got_v);
            t_oct_code want;
            if (pending_codes.size() == 0) begin
                mismatches++;
                $error("unexpected result transaction: oct_u %0d, oct_v %0d", got_u, got_v);
                return;
            end
            want = pending_codes.pop_front();
            if (got_u !== want.u) begin
                mismatches++;
                $error("oct_u: expected %0d, actual %0d", want.u, got_u);
            end
            if (got_v !== want.v) begin
                mismatches++;
                $error("oct_v: expected %0d, actual %0d", want.v, got_v);
            end
        endfunction

        function int outstanding();
            return pending_codes.size();
        endfunction
    endclass

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   i_out_ready = 1'b0;
    t_comp  i_normal_x  = '0;
    t_comp  i_normal_y  = '0;
    t_comp  i_normal_z  = '0;
    logic   o_in_ready;
    logic   o_out_valid;
    t_coord o_oct_u;
    t_coord o_oct_v;

    oct_code_tracker codes = new;

    int        burst_left  = 0;
    int        idle_cycles = 0;
    int        stall_phase = 0;
    logic [15:0] ready_pattern = 16'hffff;

    octahedral_normal_encoder_top #(
        .COMPONENT_BITS(CB)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_normal_x  (i_normal_x),
        .i_normal_y  (i_normal_y),
        .i_normal_z  (i_normal_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_oct_u     (o_oct_u),
        .o_oct_v     (o_oct_v)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sender in bursts; valid is only lowered when a real gap follows
    task automatic send_normal(t_comp x, t_comp y, t_comp z);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        i_in_valid <= 1'b1;
        i_normal_x <= x;
        i_normal_y <= y;
        i_normal_z <= z;
        do @(posedge i_clk); while (!o_in_ready);
        codes.note_normal(x, y, z);
        burst_left--;
    endtask

    function automatic t_comp pick_component(int kind);
        t_comp extremes[6] = '{-32768, -32767, -1, 0, 1, 32767};
        case (kind)
            0: return t_comp'($urandom);
            1: return t_comp'($signed($urandom_range(0, 8)) - 4);
            2: return extremes[$urandom_range(0, 5)];
            default: return t_comp'($signed($urandom) >>> $urandom_range(0, 15));
        endcase
    endfunction

    // receiver stall pattern: a rotating ready mask, reloaded with a randomly chosen pattern
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 128 == 0) begin
            case ($urandom_range(0, 4))
                0, 1: ready_pattern <= 16'hffff;
                2: ready_pattern <= 16'($urandom) | 16'h0001;
                3: ready_pattern <= 16'h0101;
                default: ready_pattern <= 16'h5555;
            endcase
        end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        i_out_ready <= ready_pattern[0];
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            codes.check_code(o_oct_u, o_oct_v);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_comp x, y, z;
        int    kind;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero input, extremes, tiny sums, folding with zero signs
        send_normal(0, 0, 0);
        send_normal(32767, 0, 0);
        send_normal(-32768, 0, 0);
        send_normal(0, 32767, 0);
        send_normal(0, -32768, 0);
        send_normal(0, 0, 32767);
        send_normal(0, 0, -32768);
        send_normal(-32768, -32768, -32768);
        send_normal(32767, 32767, 32767);
        send_normal(-32768, 32767, -32768);
        send_normal(1, 0, 0);
        send_normal(0, 0, -1);
        send_normal(0, -1, -1);
        send_normal(-1, 1, -1);
        send_normal(1, 1, 1);
        send_normal(-1, 0, 1);
        send_normal(0, 5, -7);
        send_normal(3, 0, -2);
        send_normal(16384, 16384, 0);
        send_normal(1, 2, 0);
        send_normal(12345, -23456, -3000);
        send_normal(-32768, 1, 32767);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    x = pick_component(0);
                    y = pick_component(0);
                    z = pick_component(0);
                end
                3: begin
                    x = pick_component(1);
                    y = pick_component(1);
                    z = pick_component(1);
                end
                4: begin
                    x = pick_component(2);
                    y = pick_component(2);
                    z = pick_component(2);
                end
                5: begin
                    x = ($urandom_range(0, 1) == 0) ? t_comp'(0) : pick_component(3);
                    y = ($urandom_range(0, 1) == 0) ? t_comp'(0) : pick_component(3);
                    z = pick_component(0);
                end
                6: begin
                    x = pick_component(3);
                    y = pick_component(3);
                    z = pick_component(3);
                end
                default: begin
                    x = pick_component($urandom_range(0, 3));
                    y = pick_component($urandom_range(0, 3));
                    z = t_comp'(-$signed($urandom_range(1, 32768)));
                end
            endcase
            send_normal(x, y, z);
        end
        i_in_valid <= 1'b0;

        while (codes.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (codes.mismatches == 0 && codes.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
